@@ src/igupb_pkg.sv @@
// Package for the idle-gap UART packet buffer: operation and result codes,
// register indexes, reset values and the types shared by its modules.
// No dependencies; the top level, igupb_ctrl and the testbench use it.
`default_nettype none

package igupb_pkg;

	localparam int RX_DEPTH_DEF = 256;
	localparam int TX_DEPTH_DEF = 256;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WHILE_SENDING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_THRESHOLD = 2'd2;

	localparam logic [15:0] IDLE_RESET = 16'd20;
	localparam logic [15:0] GAP_RESET = 16'd100;
	localparam logic [15:0] TICK_MAX = 16'hfffe;

	typedef enum logic [2:0] {
		OP_RX_BYTE  = 3'd0,
		OP_TICK     = 3'd1,
		OP_CLAIM    = 3'd2,
		OP_READ     = 3'd3,
		OP_LOAD_TX  = 3'd4,
		OP_TX_READY = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		KIND_CLAIM = 2'd0,
		KIND_READ  = 2'd1,
		KIND_TX    = 2'd2
	} kind_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] rx_data;
		logic       rx_error;
		logic [7:0] tx_data;
		logic       tx_last;
		logic [7:0] read_index;
	} item_t;

	// Result produced by one accepted item; oob marks a read beyond the buffer.
	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] length;
		logic       oob;
	} res_t;

endpackage

`default_nettype wire

@@ src/igupb_if.sv @@
// Valid/ready channel interfaces for the idle-gap UART packet buffer:
// the request channel carrying operations and the response channel.
// Depends on nothing but the widths of the block's fields.
`default_nettype none

interface igupb_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] rx_data;
	logic       rx_error;
	logic [7:0] tx_data;
	logic       tx_last;
	logic [7:0] read_index;

	modport source (output valid, output operation, output rx_data, output rx_error,
		output tx_data, output tx_last, output read_index, input ready);
	modport sink (input valid, input operation, input rx_data, input rx_error,
		input tx_data, input tx_last, input read_index, output ready);
endinterface

interface igupb_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] packet_length;
	logic [7:0] byte_value;

	modport source (output valid, output result_kind, output packet_length,
		output byte_value, input ready);
	modport sink (input valid, input result_kind, input packet_length,
		input byte_value, output ready);
endinterface

`default_nettype wire

@@ src/idle_gap_uart_packet_buffer.sv @@
// Top level of the idle-gap UART packet buffer: channels, control, the two
// byte stores and the result register.
// Depends on igupb_pkg, igupb_if, igupb_ram and igupb_ctrl.
//
//   port      dir   kind                 carries
//   req       in    valid/ready channel  operation, rx_data, rx_error, tx_data,
//                                        tx_last, read_index
//   rsp       out   valid/ready channel  result_kind, packet_length, byte_value
//   cfg_*     in    write port           register index and 16-bit data
//
// One item is taken per cycle unless the response side stalls; its result, if any,
// is in the result register in the next cycle. Each item needs at most one access
// to one byte store, whose registered read port delivers the byte alongside the
// result register. A new item is taken whenever the result register is empty or
// its transfer completes in the same cycle, so a stalled response side stalls the
// requests. After reset the counters are clear and the stores hold undefined bytes;
// no clearing pass is made.
`default_nettype none

module idle_gap_uart_packet_buffer #(
	parameter int RX_DEPTH = igupb_pkg::RX_DEPTH_DEF,
	parameter int TX_DEPTH = igupb_pkg::TX_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	igupb_req_if.sink                             req,
	igupb_rsp_if.source                           rsp,
	input  wire logic                             cfg_we,
	input  wire logic [igupb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [igupb_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);

	igupb_pkg::item_t item;
	igupb_pkg::res_t  res;
	igupb_pkg::res_t  res_q;
	logic             rsp_valid_q;
	logic             accept;

	logic             rx_we;
	logic [RX_AW-1:0] rx_waddr;
	logic [7:0]       rx_wdata;
	logic             rx_re;
	logic [RX_AW-1:0] rx_raddr;
	logic [7:0]       rx_rdata;
	logic             tx_we;
	logic [TX_AW-1:0] tx_waddr;
	logic             tx_re;
	logic [TX_AW-1:0] tx_raddr;
	logic [7:0]       tx_rdata;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;

	always_comb begin
		item.operation = igupb_pkg::op_t'(req.operation);
		item.rx_data = req.rx_data;
		item.rx_error = req.rx_error;
		item.tx_data = req.tx_data;
		item.tx_last = req.tx_last;
		item.read_index = req.read_index;
	end

	igupb_ctrl #(
		.RX_DEPTH(RX_DEPTH),
		.TX_DEPTH(TX_DEPTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.item(item),
		.rx_we(rx_we),
		.rx_waddr(rx_waddr),
		.rx_wdata(rx_wdata),
		.rx_re(rx_re),
		.rx_raddr(rx_raddr),
		.tx_we(tx_we),
		.tx_waddr(tx_waddr),
		.tx_re(tx_re),
		.tx_raddr(tx_raddr),
		.res(res)
	);

	igupb_ram #(
		.DEPTH(RX_DEPTH),
		.WIDTH(8)
	) u_rx_ram (
		.clk(clk),
		.we(rx_we),
		.waddr(rx_waddr),
		.wdata(rx_wdata),
		.re(rx_re),
		.raddr(rx_raddr),
		.rdata(rx_rdata)
	);

	igupb_ram #(
		.DEPTH(TX_DEPTH),
		.WIDTH(8)
	) u_tx_ram (
		.clk(clk),
		.we(tx_we),
		.waddr(tx_waddr),
		.wdata(req.tx_data),
		.re(tx_re),
		.raddr(tx_raddr),
		.rdata(tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= res.valid;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// The store read registers load only on accepted items, as this one does, so they stay in step.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	always_comb begin
		rsp.valid = rsp_valid_q;
		rsp.result_kind = res_q.kind;
		rsp.packet_length = res_q.length;
		unique case (res_q.kind)
			igupb_pkg::KIND_READ: rsp.byte_value = res_q.oob ? 8'h00 : rx_rdata;
			igupb_pkg::KIND_TX: rsp.byte_value = tx_rdata;
			default: rsp.byte_value = 8'h00;
		endcase
	end

	a_claim_answers: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.operation == igupb_pkg::OP_CLAIM
		|=> rsp_valid_q && res_q.kind == igupb_pkg::KIND_CLAIM)
		else $error("claim gave no claim result");

	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.operation == igupb_pkg::OP_READ
		|=> rsp_valid_q && res_q.kind == igupb_pkg::KIND_READ && res_q.length == 8'h00)
		else $error("read gave no read result");

	a_no_result_ops: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (item.operation == igupb_pkg::OP_TICK
		|| item.operation == igupb_pkg::OP_RX_BYTE
		|| item.operation == igupb_pkg::OP_LOAD_TX) |=> !rsp_valid_q)
		else $error("result from an operation that gives none");

endmodule

`default_nettype wire

@@ src/igupb_ram.sv @@
// Simple dual-port byte store: one write port and one registered read port.
// Used for both the receive and the transmit buffer; no package needed.
`default_nettype none

module igupb_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/igupb_ctrl.sv @@
// Control of the packet buffer: configuration registers, tick counters,
// buffer counts and the memory commands for each accepted item.
// Depends on igupb_pkg.
`default_nettype none

module igupb_ctrl #(
	parameter int RX_DEPTH = igupb_pkg::RX_DEPTH_DEF,
	parameter int TX_DEPTH = igupb_pkg::TX_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [igupb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [igupb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                 accept,
	input  wire igupb_pkg::item_t                     item,
	output logic                                      rx_we,
	output logic      [$clog2(RX_DEPTH)-1:0]          rx_waddr,
	output logic      [7:0]                           rx_wdata,
	output logic                                      rx_re,
	output logic      [$clog2(RX_DEPTH)-1:0]          rx_raddr,
	output logic                                      tx_we,
	output logic      [$clog2(TX_DEPTH)-1:0]          tx_waddr,
	output logic                                      tx_re,
	output logic      [$clog2(TX_DEPTH)-1:0]          tx_raddr,
	output igupb_pkg::res_t                           res
);

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int RX_CW = $clog2(RX_DEPTH + 1);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int TX_CW = $clog2(TX_DEPTH + 1);
	localparam int LEN_CAP = (RX_DEPTH - 1 < 255) ? RX_DEPTH - 1 : 255;

	logic        cws_q;
	logic [15:0] idle_thr_q;
	logic [15:0] gap_thr_q;

	logic [RX_CW-1:0] rx_count_q;
	logic             rx_full_q;
	logic [15:0]      idle_ticks_q;
	logic [15:0]      gap_ticks_q;
	logic [TX_CW-1:0] tx_fill_q;
	logic [TX_CW-1:0] tx_pos_q;
	logic             tx_active_q;

	logic             rx_good;
	logic             rx_flush;
	logic [RX_CW-1:0] rx_base;
	logic [RX_CW-1:0] rx_next;
	logic             claim_ok;
	logic             tx_load;
	logic             tx_send;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cws_q <= 1'b0;
			idle_thr_q <= igupb_pkg::IDLE_RESET;
			gap_thr_q <= igupb_pkg::GAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				igupb_pkg::CFG_CLEAR_WHILE_SENDING: cws_q <= cfg_data[0];
				igupb_pkg::CFG_IDLE_THRESHOLD: idle_thr_q <= cfg_data;
				igupb_pkg::CFG_GAP_THRESHOLD: gap_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		rx_good = accept && item.operation == igupb_pkg::OP_RX_BYTE && !item.rx_error;
		rx_flush = cws_q && tx_active_q;
		// A byte after a long enough gap starts a fresh packet.
		rx_base = (gap_ticks_q > gap_thr_q) ? '0 : rx_count_q;
		rx_next = rx_base + RX_CW'(1);
		claim_ok = (idle_ticks_q > idle_thr_q) && (rx_count_q != '0);
		tx_load = accept && item.operation == igupb_pkg::OP_LOAD_TX && !tx_active_q;
		tx_send = accept && item.operation == igupb_pkg::OP_TX_READY && tx_active_q
			&& (tx_pos_q < tx_fill_q);

		rx_we = rx_good && (rx_flush || !rx_full_q);
		rx_waddr = rx_flush ? '0 : rx_base[RX_AW-1:0];
		rx_wdata = rx_flush ? 8'h00 : item.rx_data;
		rx_re = accept && item.operation == igupb_pkg::OP_READ;
		rx_raddr = RX_AW'(item.read_index);

		tx_we = tx_load && (tx_fill_q < TX_CW'(TX_DEPTH));
		tx_waddr = tx_fill_q[TX_AW-1:0];
		tx_re = tx_send;
		tx_raddr = tx_pos_q[TX_AW-1:0];

		res.valid = 1'b0;
		res.kind = igupb_pkg::KIND_CLAIM;
		res.length = 8'h00;
		res.oob = 1'b0;
		if (accept) begin
			unique case (item.operation)
				igupb_pkg::OP_CLAIM: begin
					res.valid = 1'b1;
					if (claim_ok) begin
						res.length = (rx_count_q > RX_CW'(LEN_CAP)) ? 8'(LEN_CAP)
							: 8'(rx_count_q);
					end
				end
				igupb_pkg::OP_READ: begin
					res.valid = 1'b1;
					res.kind = igupb_pkg::KIND_READ;
					res.oob = 32'(item.read_index) >= 32'(RX_DEPTH);
				end
				igupb_pkg::OP_TX_READY: begin
					res.valid = tx_send;
					res.kind = igupb_pkg::KIND_TX;
				end
				default: ;
			endcase
		end
	end

	// Receive side state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_count_q <= '0;
			rx_full_q <= 1'b0;
			idle_ticks_q <= '0;
			gap_ticks_q <= '0;
		end else if (rx_good) begin
			idle_ticks_q <= '0;
			gap_ticks_q <= 16'd1;
			if (rx_flush) begin
				rx_count_q <= '0;
			end else if (!rx_full_q) begin
				rx_count_q <= rx_next;
				if (rx_next == RX_CW'(RX_DEPTH)) begin
					rx_full_q <= 1'b1;
				end
			end else begin
				rx_count_q <= rx_base;
			end
		end else if (accept && item.operation == igupb_pkg::OP_TICK) begin
			if (idle_ticks_q < igupb_pkg::TICK_MAX) begin
				idle_ticks_q <= idle_ticks_q + 16'd1;
			end
			if (gap_ticks_q < igupb_pkg::TICK_MAX) begin
				gap_ticks_q <= gap_ticks_q + 16'd1;
			end
		end else if (accept && item.operation == igupb_pkg::OP_CLAIM && claim_ok) begin
			rx_count_q <= '0;
		end
	end

	// Transmit side state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_fill_q <= '0;
			tx_pos_q <= '0;
			tx_active_q <= 1'b0;
		end else if (tx_load) begin
			if (tx_we) begin
				tx_fill_q <= tx_fill_q + TX_CW'(1);
			end
			if (item.tx_last) begin
				tx_active_q <= 1'b1;
				tx_pos_q <= '0;
			end
		end else if (tx_send) begin
			tx_pos_q <= tx_pos_q + TX_CW'(1);
		end else if (accept && item.operation == igupb_pkg::OP_TX_READY && tx_active_q) begin
			// Ready after the last byte ends the message.
			tx_active_q <= 1'b0;
			tx_fill_q <= '0;
			tx_pos_q <= '0;
		end
	end

	a_tx_pos_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		tx_pos_q <= tx_fill_q)
		else $error("transmit position beyond fill");

	a_tx_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_fill_q <= TX_CW'(TX_DEPTH))
		else $error("transmit fill beyond depth");

	a_rx_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q == RX_CW'(RX_DEPTH) |-> rx_full_q)
		else $error("receive buffer at depth without full flag");

	a_tx_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!tx_active_q |-> tx_pos_q == '0)
		else $error("transmit position moved while idle");

endmodule

`default_nettype wire

@@ tb/tb_idle_gap_uart_packet_buffer.sv @@
`timescale 1ns / 100ps
// Testbench for the idle-gap UART packet buffer: directed tests, random traffic and
// a full-buffer test, each result checked against an in-bench model of the buffer.
// Depends on igupb_pkg, igupb_if and the idle_gap_uart_packet_buffer top level.

module tb_idle_gap_uart_packet_buffer;
	import igupb_pkg::*;

	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int BUF_DEPTH = 256;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PRESSURE_CYCLES = 300;
	localparam int TICK_BURST_CAP = 60;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] rx_data;
		logic       rx_error;
		logic [7:0] tx_data;
		logic       tx_last;
		logic [7:0] read_index;
	} uart_event_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] length;
		logic [7:0] value;
	} buffer_reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	igupb_req_if req_ch();
	igupb_rsp_if rsp_ch();

	idle_gap_uart_packet_buffer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Model of the buffer state and its configuration.
	logic [7:0]     rx_bytes [BUF_DEPTH];
	bit             rx_known [BUF_DEPTH];
	logic [8:0]     rx_len;
	bit             rx_sticky_full;
	logic [15:0]    quiet_ticks;
	logic [15:0]    since_byte_ticks;
	logic [7:0]     tx_bytes [BUF_DEPTH];
	logic [8:0]     tx_len;
	logic [8:0]     tx_next;
	bit             tx_sending;
	bit             cfg_flush_on_tx;
	logic [15:0]    cfg_claim_after;
	logic [15:0]    cfg_split_after;

	buffer_reply_t  expected_replies[$];
	int             stored_positions[$];
	logic [7:0]     last_claim_len;
	int             errors;
	int             live_items;
	int             send_idle_pct;
	int             recv_idle_pct;
	bit             hold_req;
	int             hold_left;
	int             quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [15:0] tick_up(input logic [15:0] count);
		return (count < TICK_MAX) ? count + 16'd1 : count;
	endfunction

	function automatic void note_written(input int idx);
		if (!rx_known[idx]) begin
			rx_known[idx] = 1'b1;
			stored_positions.push_back(idx);
		end
	endfunction

	// Advances the model by one accepted event and queues the result it owes.
	// useful is cleared for events that the buffer ignores.
	task automatic apply_buffer_event(input uart_event_t e, output bit useful);
		logic [7:0] claim_len;
		useful = 1'b1;
		case (e.op)
			OP_RX_BYTE: begin
				if (e.rx_error) begin
					useful = 1'b0;
				end else begin
					quiet_ticks = 16'd0;
					if (cfg_flush_on_tx && tx_sending) begin
						since_byte_ticks = 16'd1;
						rx_len = 9'd0;
						rx_bytes[0] = 8'h00;
						note_written(0);
					end else begin
						if (since_byte_ticks > cfg_split_after)
							rx_len = 9'd0;
						since_byte_ticks = 16'd1;
						if (!rx_sticky_full) begin
							if (rx_len < BUF_DEPTH) begin
								rx_bytes[rx_len] = e.rx_data;
								note_written(int'(rx_len));
								rx_len = rx_len + 9'd1;
							end
							if (rx_len >= BUF_DEPTH)
								rx_sticky_full = 1'b1;
						end
					end
				end
			end
			OP_TICK: begin
				quiet_ticks = tick_up(quiet_ticks);
				since_byte_ticks = tick_up(since_byte_ticks);
			end
			OP_CLAIM: begin
				claim_len = 8'd0;
				if (quiet_ticks > cfg_claim_after && rx_len != 9'd0) begin
					claim_len = (rx_len > 9'd255) ? 8'd255 : rx_len[7:0];
					rx_len = 9'd0;
				end
				last_claim_len = claim_len;
				expected_replies.push_back(buffer_reply_t'{kind: KIND_CLAIM,
					length: claim_len, value: 8'h00});
			end
			OP_READ: begin
				expected_replies.push_back(buffer_reply_t'{kind: KIND_READ,
					length: 8'h00, value: rx_bytes[e.read_index]});
			end
			OP_LOAD_TX: begin
				if (tx_sending) begin
					useful = 1'b0;
				end else begin
					// A byte beyond the store is lost, but the last flag still counts.
					if (tx_len < BUF_DEPTH) begin
						tx_bytes[tx_len] = e.tx_data;
						tx_len = tx_len + 9'd1;
					end
					if (e.tx_last) begin
						tx_sending = 1'b1;
						tx_next = 9'd0;
					end
				end
			end
			OP_TX_READY: begin
				if (!tx_sending) begin
					useful = 1'b0;
				end else if (tx_next < tx_len) begin
					expected_replies.push_back(buffer_reply_t'{kind: KIND_TX,
						length: 8'h00, value: tx_bytes[tx_next]});
					tx_next = tx_next + 9'd1;
				end else begin
					tx_sending = 1'b0;
					tx_len = 9'd0;
					tx_next = 9'd0;
				end
			end
			default: useful = 1'b0;
		endcase
	endtask

	// Offers one event on the request channel; returns at the edge of its transfer.
	task automatic send_item(input uart_event_t e);
		bit useful;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= e.op;
		req_ch.rx_data    <= e.rx_data;
		req_ch.rx_error   <= e.rx_error;
		req_ch.tx_data    <= e.tx_data;
		req_ch.tx_last    <= e.tx_last;
		req_ch.read_index <= e.read_index;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		apply_buffer_event(e, useful);
		if (useful)
			live_items++;
	endtask

	// Unused data and index fields carry random values so that the block must ignore them.
	function automatic uart_event_t blank_event(input logic [2:0] op);
		uart_event_t e;
		e.op = op;
		e.rx_data = 8'($urandom);
		e.rx_error = 1'b0;
		e.tx_data = 8'($urandom);
		e.tx_last = 1'b0;
		e.read_index = 8'($urandom);
		return e;
	endfunction

	function automatic logic [7:0] pick_stored();
		if (last_claim_len != 8'd0 && $urandom_range(0, 1) == 1)
			return 8'($urandom_range(0, int'(last_claim_len) - 1));
		return 8'(stored_positions[$urandom_range(0, stored_positions.size() - 1)]);
	endfunction

	function automatic int capped(input int n);
		return (n > TICK_BURST_CAP) ? TICK_BURST_CAP : n;
	endfunction

	task automatic send_rx(input logic [7:0] data, input logic err);
		uart_event_t e;
		e = blank_event(OP_RX_BYTE);
		e.rx_data = data;
		e.rx_error = err;
		send_item(e);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(blank_event(OP_TICK));
	endtask

	task automatic send_claim();
		send_item(blank_event(OP_CLAIM));
	endtask

	task automatic send_read(input logic [7:0] idx);
		uart_event_t e;
		e = blank_event(OP_READ);
		e.read_index = idx;
		send_item(e);
	endtask

	task automatic send_load(input logic [7:0] data, input logic last);
		uart_event_t e;
		e = blank_event(OP_LOAD_TX);
		e.tx_data = data;
		e.tx_last = last;
		send_item(e);
	endtask

	task automatic send_readies(input int n);
		repeat (n) send_item(blank_event(OP_TX_READY));
	endtask

	task automatic set_pace(input int sender_pct, input int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
	endtask

	// Drops valid and waits until every owed result has been transferred.
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_CLEAR_WHILE_SENDING: cfg_flush_on_tx = val[0];
			CFG_IDLE_THRESHOLD:      cfg_claim_after = val;
			CFG_GAP_THRESHOLD:       cfg_split_after = val;
			default: ;
		endcase
	endtask

	task automatic test_reset_values();
		send_claim();
		send_rx(8'h00, 1'b0);
		send_rx(8'hff, 1'b0);
		send_rx(8'h5a, 1'b1);
		send_ticks(20);
		send_claim();
		send_ticks(1);
		send_claim();
		send_read(8'd0);
		send_read(8'd1);
		send_item(blank_event(OP_SPARE_LO));
		send_item(blank_event(OP_SPARE_HI));
		send_readies(1);
	endtask

	task automatic test_transmit_drain();
		send_load(8'h00, 1'b0);
		send_load(8'hff, 1'b0);
		send_load(8'ha5, 1'b1);
		// Loaded while sending, so it must be ignored.
		send_load(8'h11, 1'b1);
		send_readies(5);
	endtask

	task automatic test_clear_while_sending();
		write_reg(CFG_CLEAR_WHILE_SENDING, 16'd1);
		send_load(8'h3c, 1'b1);
		send_rx(8'h77, 1'b0);
		send_read(8'd0);
		send_ticks(21);
		send_claim();
		send_readies(2);
		send_rx(8'h42, 1'b0);
		send_read(8'd0);
		write_reg(CFG_CLEAR_WHILE_SENDING, 16'd0);
	endtask

	task automatic test_threshold_extremes();
		write_reg(CFG_IDLE_THRESHOLD, 16'd0);
		write_reg(CFG_GAP_THRESHOLD, 16'd0);
		send_rx(8'h81, 1'b0);
		send_claim();
		send_ticks(1);
		send_claim();
		send_rx(8'h18, 1'b0);
		send_ticks(1);
		send_rx(8'he7, 1'b0);
		send_ticks(1);
		send_claim();
		send_read(8'd0);
		write_reg(CFG_IDLE_THRESHOLD, 16'd65534);
		write_reg(CFG_GAP_THRESHOLD, 16'd65534);
		send_rx(8'h0f, 1'b0);
		send_ticks(30);
		send_claim();
	endtask

	task automatic test_transmit_overflow();
		set_pace(0, 0);
		for (int i = 0; i < BUF_DEPTH + 2; i++)
			send_load(8'($urandom), i == BUF_DEPTH + 1);
		send_readies(BUF_DEPTH + 1);
	endtask

	// The receiver holds off while claims and reads keep coming, so the result
	// register fills and the request side has to stall.
	task automatic test_output_backpressure();
		set_pace(0, 0);
		hold_req = 1'b1;
		for (int i = 0; i < 24; i++) begin
			if (i % 2 == 0 || stored_positions.size() == 0)
				send_claim();
			else
				send_read(pick_stored());
		end
	endtask

	task automatic run_random_phase(input int target);
		int goal;
		int n;
		uart_event_t e;
		goal = live_items + target;
		while (live_items < goal) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					n = $urandom_range(1, 10);
					repeat (n) begin
						send_rx(8'($urandom), $urandom_range(0, 7) == 0);
						if ($urandom_range(0, 3) == 0)
							send_ticks($urandom_range(0, capped(int'(cfg_split_after) + 2)));
					end
					if ($urandom_range(0, 4) == 0)
						send_ticks($urandom_range(0, capped(int'(cfg_claim_after))));
					else
						send_ticks(capped(int'(cfg_claim_after) + $urandom_range(1, 3)));
					send_claim();
					repeat ($urandom_range(0, 3))
						if (stored_positions.size() != 0)
							send_read(pick_stored());
				end
				4, 5: begin
					n = $urandom_range(1, 6);
					for (int i = 0; i < n; i++) begin
						send_load(8'($urandom), i == n - 1);
						if ($urandom_range(0, 3) == 0)
							send_rx(8'($urandom), 1'b0);
					end
					repeat (n + 1) begin
						send_readies(1);
						if ($urandom_range(0, 3) == 0)
							send_rx(8'($urandom), $urandom_range(0, 3) == 0);
					end
				end
				default: begin
					repeat ($urandom_range(1, 4)) begin
						e = blank_event(3'($urandom_range(0, 7)));
						e.rx_error = ($urandom_range(0, 3) == 0);
						e.tx_last = ($urandom_range(0, 3) == 0);
						if (e.op == OP_READ) begin
							if (stored_positions.size() == 0)
								e.op = OP_TICK;
							else
								e.read_index = pick_stored();
						end
						send_item(e);
					end
				end
			endcase
		end
	endtask

	task automatic test_random_traffic();
		write_reg(CFG_CLEAR_WHILE_SENDING, 16'd0);
		write_reg(CFG_IDLE_THRESHOLD, 16'd3);
		write_reg(CFG_GAP_THRESHOLD, 16'd8);
		set_pace(29, 82);
		run_random_phase(110);
		write_reg(CFG_CLEAR_WHILE_SENDING, 16'd1);
		write_reg(CFG_IDLE_THRESHOLD, 16'($urandom_range(0, 15)));
		write_reg(CFG_GAP_THRESHOLD, 16'($urandom_range(0, 40)));
		set_pace(82, 29);
		run_random_phase(110);
		write_reg(CFG_CLEAR_WHILE_SENDING, 16'($urandom_range(0, 1)));
		write_reg(CFG_IDLE_THRESHOLD, 16'($urandom_range(0, 20)));
		write_reg(CFG_GAP_THRESHOLD, 16'($urandom_range(0, 30)));
		set_pace(0, 0);
		run_random_phase(110);
	endtask

	// Runs last: once the full flag is set only a reset would clear it.
	task automatic test_sticky_full();
		write_reg(CFG_CLEAR_WHILE_SENDING, 16'd0);
		write_reg(CFG_IDLE_THRESHOLD, 16'd0);
		write_reg(CFG_GAP_THRESHOLD, 16'd65534);
		set_pace(29, 82);
		repeat (BUF_DEPTH + 4) send_rx(8'($urandom), 1'b0);
		send_read(8'd255);
		send_read(8'd0);
		send_read(8'd128);
		send_ticks(1);
		send_claim();
		send_rx(8'h99, 1'b0);
		send_ticks(1);
		send_claim();
	endtask

	task automatic finish_run();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb_idle_gap_uart_packet_buffer: clean");
		else
			$display("tb_idle_gap_uart_packet_buffer: errors");
		$finish;
	endtask

	// Result side: random stalls, plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = PRESSURE_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		buffer_reply_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual kind %0d length %0d byte %h",
					$time, rsp_ch.result_kind, rsp_ch.packet_length, rsp_ch.byte_value);
			end else begin
				want = expected_replies.pop_front();
				if (rsp_ch.result_kind !== want.kind) begin
					errors++;
					$display("%0t: result_kind expected %0d actual %0d",
						$time, want.kind, rsp_ch.result_kind);
				end
				if (rsp_ch.packet_length !== want.length) begin
					errors++;
					$display("%0t: packet_length expected %0d actual %0d",
						$time, want.length, rsp_ch.packet_length);
				end
				if (rsp_ch.byte_value !== want.value) begin
					errors++;
					$display("%0t: byte_value expected %h actual %h",
						$time, want.value, rsp_ch.byte_value);
				end
			end
		end
	end

	// Ends the run if neither channel completes a transfer for too long.
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_idle_gap_uart_packet_buffer: errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_TICK;
		req_ch.rx_data = 8'h00;
		req_ch.rx_error = 1'b0;
		req_ch.tx_data = 8'h00;
		req_ch.tx_last = 1'b0;
		req_ch.read_index = 8'h00;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < BUF_DEPTH; i++) begin
			rx_bytes[i] = 8'h00;
			rx_known[i] = 1'b0;
			tx_bytes[i] = 8'h00;
		end
		rx_len = 9'd0;
		rx_sticky_full = 1'b0;
		quiet_ticks = 16'd0;
		since_byte_ticks = 16'd0;
		tx_len = 9'd0;
		tx_next = 9'd0;
		tx_sending = 1'b0;
		cfg_flush_on_tx = 1'b0;
		cfg_claim_after = IDLE_RESET;
		cfg_split_after = GAP_RESET;
		last_claim_len = 8'd0;
		errors = 0;
		live_items = 0;
		hold_req = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		set_pace(29, 82);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_transmit_drain();
		test_clear_while_sending();
		test_threshold_extremes();
		test_transmit_overflow();
		test_output_backpressure();
		test_random_traffic();
		test_sticky_full();
		finish_run();
	end

endmodule

@@ idle_gap_uart_packet_buffer.f @@
src/igupb_pkg.sv
src/igupb_if.sv
src/igupb_ram.sv
src/igupb_ctrl.sv
src/idle_gap_uart_packet_buffer.sv
tb/tb_idle_gap_uart_packet_buffer.sv
